// ===== rtl/core/pn3d_pkg.sv =====
// ----------------------------------------------------------------------------
// pn3d_pkg
// Shared constants, the permutation table and its lookup for the 3-D
// gradient noise pipeline.
// ----------------------------------------------------------------------------
package pn3d_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CUBE_BITS     = 8;
  localparam int OUT_W         = 18;
  localparam int OUT_FRAC      = 16;

  localparam logic [3:0] GRAD_U_LIMIT = 4'd8;
  localparam logic [3:0] GRAD_V_LIMIT = 4'd4;
  localparam logic [3:0] GRAD_DUP_A   = 4'd12;
  localparam logic [3:0] GRAD_DUP_B   = 4'd13;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    perm_lookup = PERM_ROM[idx];
  endfunction

endpackage

// ===== rtl/core/pn3d_fade.sv =====
// ----------------------------------------------------------------------------
// pn3d_fade
// Five-stage quintic fade curve 6t^5-15t^4+10t^3 in Horner form.
// ----------------------------------------------------------------------------
module pn3d_fade import pn3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [FRAC_BITS-1:0]        frac,
  output logic signed [FRAC_BITS+5:0] fade
);

  localparam int FW = FRAC_BITS + 6;
  localparam int PW = FW + FRAC_BITS + 1;
  localparam logic signed [FW-1:0] ONE  = FW'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic [FRAC_BITS-1:0] t1, t2, t3, t4;
  logic signed [FW-1:0] a1, b2, c3, d4;
  logic signed [FW-1:0] t_in;
  logic signed [PW-1:0] p2, p3, p4, p5;

  assign t_in = $signed({{(FW-FRAC_BITS){1'b0}}, frac});
  assign p2 = $signed({1'b0, t1}) * a1 + HALF;
  assign p3 = $signed({1'b0, t2}) * b2 + HALF;
  assign p4 = $signed({1'b0, t3}) * c3 + HALF;
  assign p5 = $signed({1'b0, t4}) * d4 + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      t1   <= frac;
      a1   <= FW'(6) * t_in - FW'(15) * ONE;
      t2   <= t1;
      b2   <= FW'((p2 >>> FRAC_BITS) + PW'(FW'(10) * ONE));
      t3   <= t2;
      c3   <= FW'(p3 >>> FRAC_BITS);
      t4   <= t3;
      d4   <= FW'(p4 >>> FRAC_BITS);
      fade <= FW'(p5 >>> FRAC_BITS);
    end
  end

endmodule

// ===== rtl/core/pn3d_hash.sv =====
// ----------------------------------------------------------------------------
// pn3d_hash
// Five-stage corner hash and gradient dot product for the eight cube corners.
// ----------------------------------------------------------------------------
module pn3d_hash import pn3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [COORD_W-1:0]          coord_x,
  input  logic [COORD_W-1:0]          coord_y,
  input  logic [COORD_W-1:0]          coord_z,
  output logic signed [FRAC_BITS+2:0] dot [8]
);

  localparam int DW = FRAC_BITS + 3;
  localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;

  logic [FRAC_BITS-1:0] fx1, fy1, fz1, fx2, fy2, fz2, fx3, fy3, fz3, fx4, fy4, fz4;
  logic [7:0] cy1, cz1, cz2;
  logic [7:0] pa1, pb1;
  logic [7:0] ha2, ha12, hb2, hb12;
  logic [7:0] aa3, ab3, ba3, bb3;
  logic [7:0] hc4 [8];
  logic [7:0] sa, sb;
  logic signed [DW-1:0] x0, y0, z0, x1, y1, z1;

  function automatic logic signed [DW-1:0] grad(input logic [7:0] code,
      input logic signed [DW-1:0] gx, input logic signed [DW-1:0] gy,
      input logic signed [DW-1:0] gz);
    logic [3:0] h;
    logic signed [DW-1:0] gu, gv;
    h  = code[3:0];
    gu = (h < GRAD_U_LIMIT || h == GRAD_DUP_A || h == GRAD_DUP_B) ? gx : gy;
    gv = (h < GRAD_V_LIMIT || h == GRAD_DUP_A || h == GRAD_DUP_B) ? gy : gz;
    grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  assign sa = pa1 + cy1;
  assign sb = pb1 + cy1;
  assign x0 = $signed({3'b000, fx4});
  assign y0 = $signed({3'b000, fy4});
  assign z0 = $signed({3'b000, fz4});
  assign x1 = x0 - ONE;
  assign y1 = y0 - ONE;
  assign z1 = z0 - ONE;

  always_ff @(posedge clk) begin
    if (en) begin
      pa1  <= perm_lookup(coord_x[FRAC_BITS+7:FRAC_BITS]);
      pb1  <= perm_lookup(coord_x[FRAC_BITS+7:FRAC_BITS] + 8'd1);
      cy1  <= coord_y[FRAC_BITS+7:FRAC_BITS];
      cz1  <= coord_z[FRAC_BITS+7:FRAC_BITS];
      fx1  <= coord_x[FRAC_BITS-1:0];
      fy1  <= coord_y[FRAC_BITS-1:0];
      fz1  <= coord_z[FRAC_BITS-1:0];
      ha2  <= perm_lookup(sa);
      ha12 <= perm_lookup(sa + 8'd1);
      hb2  <= perm_lookup(sb);
      hb12 <= perm_lookup(sb + 8'd1);
      cz2  <= cz1;
      fx2  <= fx1;
      fy2  <= fy1;
      fz2  <= fz1;
      aa3  <= ha2 + cz2;
      ab3  <= ha12 + cz2;
      ba3  <= hb2 + cz2;
      bb3  <= hb12 + cz2;
      fx3  <= fx2;
      fy3  <= fy2;
      fz3  <= fz2;
      hc4[0] <= perm_lookup(aa3);
      hc4[1] <= perm_lookup(ba3);
      hc4[2] <= perm_lookup(ab3);
      hc4[3] <= perm_lookup(bb3);
      hc4[4] <= perm_lookup(aa3 + 8'd1);
      hc4[5] <= perm_lookup(ba3 + 8'd1);
      hc4[6] <= perm_lookup(ab3 + 8'd1);
      hc4[7] <= perm_lookup(bb3 + 8'd1);
      fx4  <= fx3;
      fy4  <= fy3;
      fz4  <= fz3;
      dot[0] <= grad(hc4[0], x0, y0, z0);
      dot[1] <= grad(hc4[1], x1, y0, z0);
      dot[2] <= grad(hc4[2], x0, y1, z0);
      dot[3] <= grad(hc4[3], x1, y1, z0);
      dot[4] <= grad(hc4[4], x0, y0, z1);
      dot[5] <= grad(hc4[5], x1, y0, z1);
      dot[6] <= grad(hc4[6], x0, y1, z1);
      dot[7] <= grad(hc4[7], x1, y1, z1);
    end
  end

endmodule

// ===== rtl/core/pn3d_blend.sv =====
// ----------------------------------------------------------------------------
// pn3d_blend
// Two-stage linear blend a + round(t * (b - a)).
// ----------------------------------------------------------------------------
module pn3d_blend import pn3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+5:0] t,
  input  logic signed [FRAC_BITS+3:0] a,
  input  logic signed [FRAC_BITS+3:0] b,
  output logic signed [FRAC_BITS+3:0] y
);

  localparam int FW = FRAC_BITS + 6;
  localparam int BW = FRAC_BITS + 4;
  localparam int PW = FW + BW + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [BW:0]   diff;
  logic signed [BW-1:0] a_d;
  logic signed [FW-1:0] t_d;
  logic signed [PW-1:0] prod;

  assign prod = t_d * diff + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= (BW+1)'(b) - (BW+1)'(a);
      a_d  <= a;
      t_d  <= t;
      y    <= a_d + BW'(prod >>> FRAC_BITS);
    end
  end

endmodule

// ===== rtl/core/perlin_noise_3d.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3-D gradient noise of one fixed-point point per item.
// ----------------------------------------------------------------------------
// The input channel takes coord_x, coord_y and coord_z with in_valid and
// in_stall; the output channel gives noise_value with out_valid and
// out_stall. An item is taken at an edge with valid high and stall low.
// The pipeline has twelve stages: five for the cube hash and the fade
// curves, six for the three blend levels and one for rescale and clamp.
// An output register follows the pipeline, and one item can enter in
// every cycle while in_stall is low. When the receiver stalls, the next
// finished item goes to a skid register; only while that register is
// full does in_stall rise and the whole pipeline hold. Reset empties the
// pipeline, the output register and the skid register.
// ----------------------------------------------------------------------------
module perlin_noise_3d import pn3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] noise_value
);

  localparam int FW = FRAC_BITS + 6;
  localparam int DW = FRAC_BITS + 3;
  localparam int BW = FRAC_BITS + 4;
  localparam int SW = BW + 16;
  localparam int STAGES = 12;
  localparam logic signed [SW-1:0] SAT_HI = SW'(131071);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(131072);

  logic en, push;
  logic [STAGES-1:0] vld;
  logic signed [FW-1:0] fu, fv, fw, fv1, fv2, fw1, fw2, fw3, fw4;
  logic signed [DW-1:0] dot [8];
  logic signed [BW-1:0] l1 [4];
  logic signed [BW-1:0] l2 [2];
  logic signed [BW-1:0] l3;
  logic signed [SW-1:0] wide, scaled, clamped;
  logic signed [OUT_W-1:0] res, skid;
  logic skid_vld;

  assign en       = !skid_vld;
  assign in_stall = skid_vld;
  assign push     = en && vld[STAGES-1];

  pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk(clk), .en(en), .frac(coord_x[FRAC_BITS-1:0]), .fade(fu));
  pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk(clk), .en(en), .frac(coord_y[FRAC_BITS-1:0]), .fade(fv));
  pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
    .clk(clk), .en(en), .frac(coord_z[FRAC_BITS-1:0]), .fade(fw));

  pn3d_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
    .clk(clk), .en(en), .coord_x(coord_x), .coord_y(coord_y),
    .coord_z(coord_z), .dot(dot));

  for (genvar i = 0; i < 4; i++) begin : g_l1
    pn3d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clk(clk), .en(en), .t(fu), .a(BW'(dot[2*i])), .b(BW'(dot[2*i+1])),
      .y(l1[i]));
  end

  for (genvar i = 0; i < 2; i++) begin : g_l2
    pn3d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clk(clk), .en(en), .t(fv2), .a(l1[2*i]), .b(l1[2*i+1]), .y(l2[i]));
  end

  pn3d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_z (
    .clk(clk), .en(en), .t(fw4), .a(l2[0]), .b(l2[1]), .y(l3));

  assign wide = SW'(l3);

  if (FRAC_BITS > OUT_FRAC) begin : g_down
    assign scaled = (wide + (SW'(1) <<< (FRAC_BITS - OUT_FRAC - 1)))
                    >>> (FRAC_BITS - OUT_FRAC);
  end else begin : g_up
    assign scaled = wide <<< (OUT_FRAC - FRAC_BITS);
  end

  always_comb begin
    if (scaled > SAT_HI) begin
      clamped = SAT_HI;
    end else if (scaled < SAT_LO) begin
      clamped = SAT_LO;
    end else begin
      clamped = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fv1 <= fv;
      fv2 <= fv1;
      fw1 <= fw;
      fw2 <= fw1;
      fw3 <= fw2;
      fw4 <= fw3;
      res <= OUT_W'(clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else begin
      if (en) begin
        vld <= {vld[STAGES-2:0], in_valid};
      end
      if (!out_valid || !out_stall) begin
        if (skid_vld) begin
          out_valid   <= 1'b1;
          noise_value <= skid;
          skid_vld    <= 1'b0;
        end else if (push) begin
          out_valid   <= 1'b1;
          noise_value <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        skid_vld <= 1'b1;
        skid     <= res;
      end
    end
  end

endmodule

// ===== dv/perlin_noise_3d_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_3d_tb
// Self-checking bench for the 3-D gradient noise pipeline. A driver offers
// coordinate items from a queue, a monitor takes noise values, and a
// behavioral noise calculation predicts each value, compared in order.
// ----------------------------------------------------------------------------
module perlin_noise_3d_tb;
  import pn3d_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] noise_value;

  point_t pending_points[$];
  logic signed [OUT_W-1:0] expected_noise[$];
  int error_count;
  int drv_idle_pct;
  int mon_idle_pct;
  int hold_cycles;
  bit drain_pause;

  perlin_noise_3d #(.FRAC_BITS(FB)) u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint fix_mul(longint a, longint b);
    fix_mul = (a * b + (longint'(1) <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint fade(longint t);
    longint one;
    longint acc;
    one = longint'(1) <<< FB;
    acc = fix_mul(t, 6 * t - 15 * one) + 10 * one;
    acc = fix_mul(t, acc);
    acc = fix_mul(t, acc);
    fade = fix_mul(t, acc);
  endfunction

  function automatic longint lerp(longint t, longint a, longint b);
    lerp = a + fix_mul(t, b - a);
  endfunction

  function automatic longint grad(logic [7:0] code, longint x, longint y, longint z);
    logic [3:0] h;
    longint u;
    longint v;
    h = code[3:0];
    u = (h < GRAD_U_LIMIT || h == GRAD_DUP_A || h == GRAD_DUP_B) ? x : y;
    v = (h < GRAD_V_LIMIT || h == GRAD_DUP_A || h == GRAD_DUP_B) ? y : z;
    grad = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] hash8(int unsigned i);
    logic [7:0] idx;
    idx = i[7:0];
    hash8 = PERM_ROM[idx];
  endfunction

  function automatic logic signed [OUT_W-1:0] noise_at(point_t p);
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    int unsigned cx, cy, cz, a, b, aa, ab, ba, bb;
    longint one, x, y, z, x1, y1, z1, u, v, w, n;
    one = longint'(1) <<< FB;
    rx = p.x;
    ry = p.y;
    rz = p.z;
    cx = (rx >> FB) & 255;
    cy = (ry >> FB) & 255;
    cz = (rz >> FB) & 255;
    x = longint'(rx & ((32'd1 << FB) - 1));
    y = longint'(ry & ((32'd1 << FB) - 1));
    z = longint'(rz & ((32'd1 << FB) - 1));
    u = fade(x);
    v = fade(y);
    w = fade(z);
    a = hash8(cx) + cy;
    b = hash8(cx + 1) + cy;
    aa = hash8(a) + cz;
    ab = hash8(a + 1) + cz;
    ba = hash8(b) + cz;
    bb = hash8(b + 1) + cz;
    x1 = x - one;
    y1 = y - one;
    z1 = z - one;
    n = lerp(w,
      lerp(v, lerp(u, grad(hash8(aa), x, y, z), grad(hash8(ba), x1, y, z)),
              lerp(u, grad(hash8(ab), x, y1, z), grad(hash8(bb), x1, y1, z))),
      lerp(v, lerp(u, grad(hash8(aa + 1), x, y, z1), grad(hash8(ba + 1), x1, y, z1)),
              lerp(u, grad(hash8(ab + 1), x, y1, z1),
                   grad(hash8(bb + 1), x1, y1, z1))));
    if (FB <= OUT_FRAC) begin
      n = n <<< (OUT_FRAC - FB);
    end else begin
      n = (n + (longint'(1) <<< (FB - OUT_FRAC - 1))) >>> (FB - OUT_FRAC);
    end
    if (n > 131071) begin
      n = 131071;
    end
    if (n < -131072) begin
      n = -131072;
    end
    noise_at = n[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: rand_coord = $urandom;
      1: rand_coord = {{16{$urandom_range(0, 1) == 1}}, 16'h0} | $urandom_range(0, 32'h7FFFF);
      2: rand_coord = {16'($urandom_range(0, 65535) & 32'hFF00 | $urandom_range(0, 255)),
                       16'hFFFF};
      3: rand_coord = {16'($urandom_range(0, 65535)), 16'h0};
      default: rand_coord = $urandom;
    endcase
  endfunction

  task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.push_back(p);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
    end else begin
      if (in_valid) begin
        expected_noise.push_back(noise_at('{coord_x, coord_y, coord_z}));
      end
      if (pending_points.size() > 0 && !drain_pause &&
          $urandom_range(0, 99) >= drv_idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        in_valid <= 1'b1;
        coord_x <= p.x;
        coord_y <= p.y;
        coord_z <= p.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_noise.size() == 0) begin
          report_mismatch($sformatf("unexpected noise_value %0d", noise_value));
        end else begin
          logic signed [OUT_W-1:0] exp_v;
          exp_v = expected_noise.pop_front();
          if (noise_value !== exp_v) begin
            report_mismatch($sformatf("noise_value %0d, expected %0d", noise_value, exp_v));
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < mon_idle_pct);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    error_count = 0;
    hold_cycles = 0;
    drain_pause = 1'b0;
    drv_idle_pct = 35;
    mon_idle_pct = 35;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_point(32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_point(32'h0000FFFF, 32'h00008000, 32'h00000001);
    add_point(32'hFFFF8000, 32'h00018000, 32'hFFFE4000);
    add_point(32'h00FF8000, 32'h00FF8000, 32'h00FF8000);
    add_point(32'h55555555, 32'hAAAAAAAA, 32'h5A5A5A5A);
    add_point(32'hAAAAAAAA, 32'h55555555, 32'hA5A5A5A5);
    for (int i = 0; i < 12; i++) begin
      add_point({16'(i * 37), 16'(i * 5461)}, {16'(i * 91), 16'(65535 - i * 4000)},
                {16'(i * 13), 16'(i * 3000 + 7)});
    end
    wait (pending_points.size() == 0);

    drv_idle_pct = 0;
    mon_idle_pct = 0;
    for (int i = 0; i < 300; i++) begin
      add_point(rand_coord(), rand_coord(), rand_coord());
    end
    wait (pending_points.size() < 250);
    hold_cycles = 60;
    wait (pending_points.size() == 0);

    drain_pause = 1'b1;
    @(posedge clk);
    wait (expected_noise.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
    drain_pause = 1'b0;

    drv_idle_pct = 35;
    mon_idle_pct = 35;
    for (int i = 0; i < 1330; i++) begin
      add_point(rand_coord(), rand_coord(), rand_coord());
    end
    wait (pending_points.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_noise.size() == 0);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pn3d_pkg.sv
rtl/core/pn3d_fade.sv
rtl/core/pn3d_hash.sv
rtl/core/pn3d_blend.sv
rtl/core/perlin_noise_3d.sv
dv/perlin_noise_3d_tb.sv
